### rtl/core/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// shared types, codes and sizes of the sorted id set core
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int CAPACITY  = 64;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int ID_W      = 32;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [ID_W-1:0] id_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [MODE_W-1:0]      mode_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	// operation codes of a request word
	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_REMOVE = 2'd1;
	localparam mode_t MODE_LIST   = 2'd2;
	localparam mode_t MODE_NONE   = 2'd3;

	// status codes of a response word
	localparam status_t STATUS_OK      = 3'd0;
	localparam status_t STATUS_INVALID = 3'd1;
	localparam status_t STATUS_PRESENT = 3'd2;
	localparam status_t STATUS_ABSENT  = 3'd3;
	localparam status_t STATUS_FULL    = 3'd4;

	// configuration register indexes
	localparam cfg_idx_t CFG_MIN_ID = 1'b0;
	localparam cfg_idx_t CFG_MAX_ID = 1'b1;

	localparam id_t MIN_ID_RST = 32'sd1;
	localparam id_t MAX_ID_RST = 32'sh7fff_ffff;

	// per-cycle command to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD   = 3'd0,
		OP_CMP    = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_ROTATE = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		id_t      id;
		cnt_t     count;
	} chain_ctl_t;

endpackage

### rtl/core/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi_if
// request and response channels of the sorted id set core
// ----------------------------------------------------------------------------
interface ssi_req_if import ssi_pkg::*; ();
	logic  valid;
	logic  ready;
	mode_t mode;
	id_t   ident;

	modport source (output valid, output mode, output ident, input ready);
	modport sink   (input valid, input mode, input ident, output ready);
endinterface

interface ssi_rsp_if import ssi_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	id_t     entry;
	logic    last;
	logic    empty_res;
	cnt_t    count;

	modport source (output valid, output status, output entry, output last,
		output empty_res, output count, input ready);
	modport sink   (input valid, input status, input entry, input last,
		input empty_res, input count, output ready);
endinterface

### rtl/core/sorted_id_set_core.sv
// ----------------------------------------------------------------------------
// sorted_id_set_core
// bounded set of distinct signed ids kept in ascending order in a cell chain
// ----------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells, cell 0 holding the smallest id.
// For an insert or remove, every cell compares its id against the request in
// the cycle the word is accepted and registers less-than and equal flags;
// once the output register is free, the found flag is reduced over the
// chain, the status is decided and, on a successful update, the cells at and
// above the compare point shift one place in the same edge (right for insert,
// left for remove). A list gives one word per stored id: the chain rotates
// one place per word, cell 0 feeding the response, and is back in order once
// every id is sent. An empty list, an out-of-range id and the unused mode
// code give a single word. One request is worked on at a time; a new request
// is taken as soon as the previous one has put its last word in the output
// register, even while that word still waits to be taken. Configuration
// writes go straight into the min/max registers and are expected while idle.
// ----------------------------------------------------------------------------
module sorted_id_set_core import ssi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ssi_req_if.sink   req,
	ssi_rsp_if.source rsp,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_idx,
	input  id_t       cfg_data
);

	// control sequence, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_LIST = 3'b100
	} state_t;

	state_t     state_q, state_d;
	mode_t      mode_q;
	id_t        id_q;
	cnt_t       count_q, count_d;
	idx_t       list_idx_q, list_idx_d;
	id_t        min_q, max_q;

	// output register
	logic       out_valid_q;
	status_t    out_status_q;
	id_t        out_entry_q;
	logic       out_last_q;
	logic       out_empty_q;
	cnt_t       out_count_q;

	chain_ctl_t ctl;
	id_t        head;
	logic       found;

	logic       accept;
	logic       out_free;
	logic       invalid;
	logic       full;
	logic       list_last;

	// next response word
	logic       emit;
	status_t    o_status;
	id_t        o_entry;
	logic       o_last;
	logic       o_empty;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	// output register can take a word this cycle
	assign out_free  = !out_valid_q || rsp.ready;
	assign invalid   = (mode_q == MODE_NONE) || (id_q < min_q) || (id_q > max_q);
	assign full      = count_q >= CNT_W'(CAPACITY);
	assign list_last = (CNT_W'(list_idx_q) + CNT_W'(1)) == count_q;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		list_idx_d = list_idx_q;
		ctl.op     = OP_HOLD;
		// compare uses the word on the port, updates use the latched id
		ctl.id     = (state_q == ST_IDLE) ? req.ident : id_q;
		ctl.count  = count_q;
		emit       = 1'b0;
		o_status   = STATUS_OK;
		o_entry    = '0;
		o_last     = 1'b1;
		o_empty    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.mode == MODE_LIST) begin
						state_d    = ST_LIST;
						list_idx_d = '0;
					end else begin
						ctl.op  = OP_CMP;
						state_d = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (invalid) begin
						o_status = STATUS_INVALID;
					end else if (mode_q == MODE_INSERT) begin
						if (found) begin
							o_status = STATUS_PRESENT;
						end else if (full) begin
							o_status = STATUS_FULL;
						end else begin
							ctl.op  = OP_INSERT;
							count_d = count_q + CNT_W'(1);
						end
					end else begin
						if (!found) begin
							o_status = STATUS_ABSENT;
						end else begin
							ctl.op  = OP_REMOVE;
							count_d = count_q - CNT_W'(1);
						end
					end
				end
			end
			ST_LIST: begin
				if (out_free) begin
					emit = 1'b1;
					if (count_q == '0) begin
						o_empty = 1'b1;
						state_d = ST_IDLE;
					end else begin
						o_entry = head;
						o_last  = list_last;
						ctl.op  = OP_ROTATE;
						if (list_last) begin
							state_d = ST_IDLE;
						end else begin
							list_idx_d = list_idx_q + IDX_W'(1);
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ssi_chain u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.head  (head),
		.found (found)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			min_q       <= MIN_ID_RST;
			max_q       <= MAX_ID_RST;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MIN_ID: min_q <= cfg_data;
					CFG_MAX_ID: max_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// request and response payload
	always_ff @(posedge clk) begin
		list_idx_q <= list_idx_d;
		if (accept) begin
			mode_q <= req.mode;
			id_q   <= req.ident;
		end
		if (emit) begin
			out_status_q <= o_status;
			out_entry_q  <= o_entry;
			out_last_q   <= o_last;
			out_empty_q  <= o_empty;
			out_count_q  <= count_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.entry     = out_entry_q;
	assign rsp.last      = out_last_q;
	assign rsp.empty_res = out_empty_q;
	assign rsp.count     = out_count_q;

	// count stays within the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	// one request changes the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
			count_q == $past(count_q) - CNT_W'(1)))
		else $error("count jumped");

	// update returns to idle in the cycle after the output register is free
	a_upd_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && out_free) |=> state_q == ST_IDLE)
		else $error("update did not finish");

	// list walk never passes the stored count
	a_list_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST && count_q != '0) |-> CNT_W'(list_idx_q) < count_q)
		else $error("list index beyond count");

	// count only moves on a word going into the output register
	a_count_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != count_d) |-> emit)
		else $error("count changed without a response word");

endmodule

### rtl/core/ssi_cell.sv
// ----------------------------------------------------------------------------
// ssi_cell
// one slot of the sorted chain: holds an id, compares, shifts or rotates
// ----------------------------------------------------------------------------
module ssi_cell import ssi_pkg::*; (
	input  logic     clk,
	input  cell_op_t op,
	input  id_t      id,
	input  logic     occ,
	input  logic     tail,
	input  logic     left_lt,
	input  id_t      left_val,
	input  id_t      right_val,
	input  id_t      first_val,
	output id_t      val,
	output logic     lt,
	output logic     eq
);

	id_t  val_q;
	logic lt_q;
	logic eq_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_CMP: begin
				lt_q <= occ && (val_q < id);
				eq_q <= occ && (val_q == id);
			end
			OP_INSERT: begin
				// slots below the insert point keep, the slot at it takes the id,
				// the rest move up by one
				if (!lt_q) begin
					val_q <= left_lt ? id : left_val;
				end
			end
			OP_REMOVE: begin
				if (!lt_q) begin
					val_q <= right_val;
				end
			end
			OP_ROTATE: begin
				val_q <= tail ? first_val : right_val;
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

### rtl/core/ssi_chain.sv
// ----------------------------------------------------------------------------
// ssi_chain
// row of cells with neighbor links and the found reduction
// ----------------------------------------------------------------------------
module ssi_chain import ssi_pkg::*; (
	input  logic       clk,
	input  chain_ctl_t ctl,
	output id_t        head,
	output logic       found
);

	id_t                 val [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occ;
		logic tail;
		logic left_lt;
		id_t  left_val;
		id_t  right_val;

		assign occ  = CNT_W'(i) < ctl.count;
		assign tail = CNT_W'(i + 1) == ctl.count;

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_val = val[0];
		end else begin : g_mid
			assign left_lt  = lt[i-1];
			assign left_val = val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = val[i];
		end else begin : g_inner
			assign right_val = val[i+1];
		end

		ssi_cell u_cell (
			.clk       (clk),
			.op        (ctl.op),
			.id        (ctl.id),
			.occ       (occ),
			.tail      (tail),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.first_val (val[0]),
			.val       (val[i]),
			.lt        (lt[i]),
			.eq        (eq[i])
		);
	end

	assign head  = val[0];
	assign found = |eq;

endmodule
